### rtl/lbpt_pkg.sv
// Package for the multi-channel LED blink and pulse timer.
// Holds the channel record, mode and opcode codes, sequencer states and scaling constants.
// Depends on nothing.
`default_nettype none

package lbpt_pkg;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_PULSE = 2'd3
  } mode_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PROG = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROG_RD,
    ST_PROG_WR,
    ST_RD,
    ST_EVAL_OFF,
    ST_EVAL_ON,
    ST_MUL,
    ST_SCALE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic        level;
    logic [15:0] counter;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
    logic [15:0] pulses;
    logic [7:0]  bright;
  } chan_rec_t;

  localparam logic [6:0]  PCT_MAX     = 7'd100;
  // 5243 / 2^19 is just above 1/100 and exact for every product below 25600.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic        REG_GLOBAL_BRIGHTNESS = 1'b0;

endpackage

`default_nettype wire

### rtl/lbpt_if.sv
// Item channel interfaces of the LED blink and pulse timer.
// One interface for input items and one for result items; no dependencies.
`default_nettype none

interface lbpt_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  channel;
  logic [1:0]  mode;
  logic [15:0] on_ticks;
  logic [15:0] off_ticks;
  logic [15:0] pulse_count;
  logic [7:0]  brightness;

  modport source (
    output valid, opcode, channel, mode, on_ticks, off_ticks, pulse_count, brightness,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, mode, on_ticks, off_ticks, pulse_count, brightness,
    output ready
  );
endinterface

interface lbpt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_channel;
  logic       level;
  logic [7:0] drive;
  logic       last;

  modport source (
    output valid, out_channel, level, drive, last,
    input  ready
  );
  modport sink (
    input  valid, out_channel, level, drive, last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/lbpt_chan_mem.sv
// Channel table of the LED blink and pulse timer: one record per channel.
// Single address, registered read; per-entry valid bits make unwritten entries read as zero.
// Depends on lbpt_pkg.
`default_nettype none

module lbpt_chan_mem
  import lbpt_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire chan_rec_t wdata_i,
  output chan_rec_t      rdata_o
);

  chan_rec_t mem_q [DEPTH];
  chan_rec_t rd_q;
  logic [DEPTH-1:0] vld_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rd_q <= mem_q[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[addr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

### rtl/multi_channel_led_blink_pulse_timer.sv
// Multi-channel LED blink and pulse timer. A program item rewrites one channel's mode, on and
// off tick counts, pulse count and brightness via a read and a write state and gives no result.
// A tick item walks the channels in index order and gives one result per channel, the last one
// flagged; each channel passes through read, off and on evaluation, multiply, scale and emit,
// and emit waits while the output holds an untaken result. Channels go one at a time through
// the single shared incrementer-comparator and multiplier, and the one-port channel table. The
// global brightness register at byte address 0 clamps low seven write bits above 100 to 100.
// Depends on lbpt_pkg, lbpt_if and lbpt_chan_mem.
`default_nettype none

module multi_channel_led_blink_pulse_timer
  import lbpt_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lbpt_in_if.sink          in_i,
  lbpt_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_e state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [6:0] gb_q;

  logic        lvl_q, lvl_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] pls_q, pls_d;
  logic [27:0] prod_q, prod_d;

  mode_e       prog_mode_q;
  logic [15:0] prog_on_q, prog_off_q, prog_pls_q;
  logic [7:0]  prog_bright_q;

  logic       out_vld_q, out_vld_d;
  logic [3:0] out_chan_q, out_chan_d;
  logic       out_lvl_q, out_lvl_d;
  logic [7:0] out_drive_q, out_drive_d;
  logic       out_last_q, out_last_d;

  chan_rec_t rec;
  chan_rec_t wdata;
  logic      we;

  logic [15:0] inc_src, inc_lim, inc_sum;
  logic        inc_exp;
  logic [14:0] mul_a;
  logic [12:0] mul_b;
  logic        is_last, out_free, prog_acc, tick_acc, in_range;
  logic        pulse;

  lbpt_chan_mem #(
    .DEPTH(CHANNELS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (we),
    .addr_i (addr_q),
    .wdata_i(wdata),
    .rdata_o(rec)
  );

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GLOBAL_BRIGHTNESS);
  assign prdata = (paddr[2] == REG_GLOBAL_BRIGHTNESS) ? 32'(gb_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_q <= PCT_MAX;
    end else if (cfg_wr) begin
      gb_q <= (pwdata[6:0] > PCT_MAX) ? PCT_MAX : pwdata[6:0];
    end
  end

  // Shared incrementer and limit compare.
  assign inc_sum = inc_src + 16'd1;
  assign inc_exp = inc_sum > inc_lim;

  assign is_last  = addr_q == AW'(CHANNELS - 1);
  assign out_free = !out_vld_q || out_o.ready;
  assign in_range = {3'b000, in_i.channel} < 7'(CHANNELS);
  assign prog_acc = in_i.valid && (state_q == ST_IDLE) && (op_e'(in_i.opcode) == OP_PROG);
  assign tick_acc = in_i.valid && (state_q == ST_IDLE) && (op_e'(in_i.opcode) == OP_TICK);
  assign pulse    = rec.mode == MODE_PULSE;

  assign in_i.ready        = state_q == ST_IDLE;
  assign out_o.valid       = out_vld_q;
  assign out_o.out_channel = out_chan_q;
  assign out_o.level       = out_lvl_q;
  assign out_o.drive       = out_drive_q;
  assign out_o.last        = out_last_q;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    lvl_d       = lvl_q;
    cnt_d       = cnt_q;
    pls_d       = pls_q;
    prod_d      = prod_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_chan_d  = out_chan_q;
    out_lvl_d   = out_lvl_q;
    out_drive_d = out_drive_q;
    out_last_d  = out_last_q;
    we          = 1'b0;
    wdata       = rec;
    inc_src     = rec.counter;
    inc_lim     = rec.off_ticks;
    mul_a       = 15'(rec.bright);
    mul_b       = 13'(gb_q);

    case (state_q)
      ST_IDLE: begin
        if (prog_acc && in_range) begin
          addr_d  = AW'(in_i.channel);
          state_d = ST_PROG_RD;
        end else if (tick_acc) begin
          addr_d  = '0;
          state_d = ST_RD;
        end
      end
      ST_PROG_RD: begin
        state_d = ST_PROG_WR;
      end
      ST_PROG_WR: begin
        we              = 1'b1;
        wdata.mode      = prog_mode_q;
        wdata.on_ticks  = prog_on_q;
        wdata.off_ticks = prog_off_q;
        wdata.pulses    = prog_pls_q;
        wdata.bright    = prog_bright_q;
        state_d         = ST_IDLE;
      end
      ST_RD: begin
        state_d = ST_EVAL_OFF;
      end
      ST_EVAL_OFF: begin
        lvl_d = rec.level;
        cnt_d = rec.counter;
        pls_d = rec.pulses;
        case (rec.mode)
          MODE_OFF: lvl_d = 1'b0;
          MODE_ON:  lvl_d = 1'b1;
          default: begin
            if (!rec.level && (!pulse || (rec.pulses != '0))) begin
              if (inc_exp) begin
                lvl_d = 1'b1;
                cnt_d = '0;
                if (pulse) begin
                  pls_d = rec.pulses - 16'd1;
                end
              end else begin
                cnt_d = inc_sum;
              end
            end
          end
        endcase
        state_d = ST_EVAL_ON;
      end
      ST_EVAL_ON: begin
        inc_src = cnt_q;
        inc_lim = rec.on_ticks;
        if (((rec.mode == MODE_BLINK) || pulse) && lvl_q) begin
          if (inc_exp) begin
            lvl_d = 1'b0;
            cnt_d = '0;
          end else begin
            cnt_d = inc_sum;
          end
        end
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = 28'(mul_a) * 28'(mul_b);
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        mul_a   = prod_q[14:0];
        mul_b   = RECIP_100;
        prod_d  = 28'(mul_a) * 28'(mul_b);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d     = 1'b1;
          out_chan_d    = 4'(addr_q);
          out_lvl_d     = lvl_q;
          out_drive_d   = lvl_q ? prod_q[RECIP_SHIFT +: 8] : 8'd0;
          out_last_d    = is_last;
          we            = 1'b1;
          wdata.level   = lvl_q;
          wdata.counter = cnt_q;
          wdata.pulses  = pls_q;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            addr_d  = addr_q + AW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      addr_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q       <= lvl_d;
    cnt_q       <= cnt_d;
    pls_q       <= pls_d;
    prod_q      <= prod_d;
    out_chan_q  <= out_chan_d;
    out_lvl_q   <= out_lvl_d;
    out_drive_q <= out_drive_d;
    out_last_q  <= out_last_d;
    if (prog_acc) begin
      prog_mode_q   <= mode_e'(in_i.mode);
      prog_on_q     <= in_i.on_ticks;
      prog_off_q    <= in_i.off_ticks;
      prog_pls_q    <= in_i.pulse_count;
      prog_bright_q <= in_i.brightness;
    end
  end

endmodule

`default_nettype wire
